@@ src/fnv_bkt_pkg.sv @@
package fnv_bkt_pkg;

  // Field widths of the channels
  localparam int unsigned HASH_BITS  = 64;
  localparam int unsigned COUNT_BITS = 17;
  localparam int unsigned INDEX_BITS = 16;

  // FNV-1a 64-bit constants; the prime is 2^40 + 435
  localparam logic [HASH_BITS-1:0] FNV_BASIS  = 64'd14695981039346656037;
  localparam int unsigned          MULT_SHIFT = 40;
  localparam logic [8:0]           MULT_LO    = 9'd435;

  // Largest usable bucket count, 2^INDEX_BITS
  localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = COUNT_BITS'(1) << INDEX_BITS;

  // Remainder unit: dividend bits retired per cycle and division cycles per key
  localparam int unsigned DIV_STEPS  = 4;
  localparam int unsigned DIV_CYCLES = HASH_BITS / DIV_STEPS;
  localparam int unsigned DIV_CW     = $clog2(DIV_CYCLES);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [HASH_BITS-1:0]  hash_value;
    logic [INDEX_BITS-1:0] bucket_index;
    logic                  bad_count;
  } out_item_t;

  // One finished key handed from the hash front to the remainder back
  typedef struct packed {
    logic [HASH_BITS-1:0]  hash;
    logic [COUNT_BITS-1:0] count;
  } key_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // h * prime mod 2^64 as a shift plus a narrow constant product
  function automatic logic [HASH_BITS-1:0] fnv_mul(input logic [HASH_BITS-1:0] h);
    logic [HASH_BITS-1:0] lo;
    lo = HASH_BITS'(h * MULT_LO);
    return (h << MULT_SHIFT) + lo;
  endfunction

endpackage

@@ src/fnv1a64_bucket_index.sv @@
// FNV-1a 64-bit hasher with bucket index. Key bytes enter one per cycle on
// the in_ channel unless the queue is full (has_byte=0 items are fillers
// or an empty final item); the item marked last closes the key and yields
// one out_ beat carrying the 64-bit hash, hash mod bucket_count, and
// bad_count when the count is zero. Counts above 65536 act as 65536. The
// byte path (XOR, then multiply by the prime as a 40-bit shift plus a 9-bit
// constant product) is combinational into the hash register. Finished keys
// wait in a QUEUE_DEPTH-entry queue for the remainder unit, which loads a
// key, retires four hash bits per cycle (skipped with a zero count) and
// holds the result beat until accepted. Long keys stream at one byte per
// cycle; short keys are paced by the remainder unit once the queue fills.
// bucket_count is written on the cfg_ channel, always ready, reset value 16.
module fnv1a64_bucket_index #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  fnv_bkt_pkg::in_item_t              in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output fnv_bkt_pkg::out_item_t             out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fnv_bkt_pkg::COUNT_BITS-1:0] cfg_data
);
  import fnv_bkt_pkg::*;

  q_status_t  q_status;
  logic       q_push;
  logic       q_pop;
  key_entry_t q_wdata;
  key_entry_t q_rdata;

  // Register writes are always accepted; the bucket count is registered
  assign cfg_ready = 1'b1;

  fnv_bkt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .q_status  (q_status),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  fnv_bkt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .pop    (q_pop),
    .rdata  (q_rdata),
    .status (q_status)
  );

  fnv_bkt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ src/fnv_bkt_front.sv @@
module fnv_bkt_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  fnv_bkt_pkg::in_item_t         in_data,
  input  logic                          cfg_valid,
  input  logic [fnv_bkt_pkg::COUNT_BITS-1:0] cfg_data,
  input  fnv_bkt_pkg::q_status_t        q_status,
  output logic                          q_push,
  output fnv_bkt_pkg::key_entry_t       q_wdata
);
  import fnv_bkt_pkg::*;

  logic [HASH_BITS-1:0]  hash_r;
  logic [HASH_BITS-1:0]  hash_nxt;
  logic [HASH_BITS-1:0]  hash_upd;
  logic [COUNT_BITS-1:0] count_r;
  logic                  accept;

  // Stall every beat while the queue is full
  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;

  // Fold in the byte when it belongs to the key
  assign hash_upd = in_data.has_byte ? fnv_mul(hash_r ^ HASH_BITS'(in_data.data_byte))
                                     : hash_r;

  // Push the finished key with its clamped bucket count
  assign q_push        = accept && in_data.last;
  assign q_wdata.hash  = hash_upd;
  assign q_wdata.count = (count_r > COUNT_LIMIT) ? COUNT_LIMIT : count_r;

  // Re-arm to the basis after the last beat of a key
  always_comb begin
    hash_nxt = hash_r;
    if (accept) begin
      hash_nxt = in_data.last ? FNV_BASIS : hash_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r  <= FNV_BASIS;
      count_r <= COUNT_BITS'(16);
    end else begin
      hash_r <= hash_nxt;
      if (cfg_valid) begin
        count_r <= cfg_data;
      end
    end
  end

endmodule

@@ src/fnv_bkt_queue.sv @@
module fnv_bkt_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  fnv_bkt_pkg::key_entry_t wdata,
  input  logic                    pop,
  output fnv_bkt_pkg::key_entry_t rdata,
  output fnv_bkt_pkg::q_status_t  status
);
  import fnv_bkt_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  key_entry_t      mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r;
  logic [AW-1:0]   rd_ptr_r;
  logic [CW-1:0]   fill_r;

  assign status.full  = (fill_r == CW'(DEPTH));
  assign status.empty = (fill_r == '0);
  assign rdata        = mem_r[rd_ptr_r];

  // Store the entry at the write pointer
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  // Advance pointers and track the fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        fill_r <= fill_r + CW'(1);
      end else if (pop && !push) begin
        fill_r <= fill_r - CW'(1);
      end
    end
  end

endmodule

@@ src/fnv_bkt_back.sv @@
module fnv_bkt_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  fnv_bkt_pkg::q_status_t  q_status,
  input  fnv_bkt_pkg::key_entry_t q_rdata,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output fnv_bkt_pkg::out_item_t  out_data
);
  import fnv_bkt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_DONE
  } state_t;

  state_t                 state_r;
  logic [HASH_BITS-1:0]   dividend_r;
  logic [COUNT_BITS-1:0]  divisor_r;
  logic [COUNT_BITS-1:0]  rem_r;
  logic [DIV_CW-1:0]      step_r;
  out_item_t              out_r;
  logic [HASH_BITS-1:0]   dividend_nxt;
  logic [COUNT_BITS-1:0]  rem_nxt;

  assign q_pop     = (state_r == S_IDLE) && !q_status.empty;
  assign out_valid = (state_r == S_DONE);
  assign out_data  = out_r;

  // Retire DIV_STEPS dividend bits by restoring shift-subtract
  always_comb begin
    logic [COUNT_BITS:0] trial;
    dividend_nxt = dividend_r;
    rem_nxt      = rem_r;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial        = {rem_nxt, dividend_nxt[HASH_BITS-1]};
      dividend_nxt = dividend_nxt << 1;
      if (trial >= {1'b0, divisor_r}) begin
        trial = trial - {1'b0, divisor_r};
      end
      rem_nxt = trial[COUNT_BITS-1:0];
    end
  end

  // Sequence: load a key, iterate the remainder, hold the result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (!q_status.empty) begin
            dividend_r       <= q_rdata.hash;
            divisor_r        <= q_rdata.count;
            rem_r            <= '0;
            step_r           <= '0;
            out_r.hash_value <= q_rdata.hash;
            if (q_rdata.count == '0) begin
              out_r.bucket_index <= '0;
              out_r.bad_count    <= 1'b1;
              state_r            <= S_DONE;
            end else begin
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          dividend_r <= dividend_nxt;
          rem_r      <= rem_nxt;
          step_r     <= step_r + DIV_CW'(1);
          if (step_r == DIV_CW'(DIV_CYCLES - 1)) begin
            out_r.bucket_index <= rem_nxt[INDEX_BITS-1:0];
            out_r.bad_count    <= 1'b0;
            state_r            <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_stall) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ tb/sv/tb_fnv1a64_bucket_index.sv @@
module tb_fnv1a64_bucket_index;
  timeunit 1ns;
  timeprecision 1ps;

  import fnv_bkt_pkg::*;

  localparam logic [HASH_BITS-1:0]  HASH_MULT    = 64'd1099511628211;
  localparam logic [COUNT_BITS-1:0] RESET_COUNT  = 17'd16;
  localparam int unsigned           DRAIN_CYCLES = 4 * (DIV_CYCLES + 2);
  localparam int unsigned           QUIET_LIMIT  = 4000;
  localparam int unsigned           PHASE_ITEMS  = 172;
  localparam int unsigned           FILLER_PCT   = 10;

  // Short scripted keys: empty keys, byte extremes, fillers inside a key,
  // and a key closed by an item without a byte
  localparam in_item_t KEY_SCRIPT [17] = '{
    {8'h00, 1'b0, 1'b1}, {8'hA5, 1'b0, 1'b1}, {8'h00, 1'b1, 1'b1}, {8'hFF, 1'b1, 1'b1},
    {8'h5A, 1'b0, 1'b0}, {8'h61, 1'b1, 1'b0}, {8'hC3, 1'b0, 1'b0}, {8'h62, 1'b1, 1'b0},
    {8'h63, 1'b1, 1'b1}, {8'h80, 1'b1, 1'b0}, {8'h7F, 1'b0, 1'b1}, {8'hFF, 1'b1, 1'b0},
    {8'hFF, 1'b1, 1'b0}, {8'h00, 1'b1, 1'b0}, {8'h01, 1'b1, 1'b1}, {8'h00, 1'b0, 1'b0},
    {8'h00, 1'b0, 1'b1}
  };

  // Tracks the running hash and holds the results still owed by the block
  class key_hash_scoreboard;
    logic [HASH_BITS-1:0]  running_hash;
    logic [COUNT_BITS-1:0] bucket_count;
    out_item_t             key_results[$];
    int unsigned           errors;
    int unsigned           checked;

    function new();
      running_hash = FNV_BASIS;
      bucket_count = RESET_COUNT;
      errors       = 0;
      checked      = 0;
    endfunction

    function void set_count(logic [COUNT_BITS-1:0] value);
      bucket_count = value;
    endfunction

    function int unsigned pending();
      return key_results.size();
    endfunction

    // Fold one accepted beat into the hash; close the key on last
    function void note_item(in_item_t item);
      logic [COUNT_BITS-1:0] usable;
      out_item_t             res;
      if (item.has_byte) begin
        running_hash = (running_hash ^ {56'd0, item.data_byte}) * HASH_MULT;
      end
      if (!item.last) return;
      usable = (bucket_count > COUNT_LIMIT) ? COUNT_LIMIT : bucket_count;
      res.hash_value   = running_hash;
      res.bad_count    = (usable == 0);
      res.bucket_index = (usable == 0) ? '0 : INDEX_BITS'(running_hash % usable);
      key_results.push_back(res);
      running_hash = FNV_BASIS;
    endfunction

    // Compare one result beat with the oldest owed result
    function void check_result(out_item_t got);
      out_item_t want;
      if (key_results.size() == 0) begin
        $error("unexpected result: hash_value %h bucket_index %0d bad_count %0b",
               got.hash_value, got.bucket_index, got.bad_count);
        errors++;
        return;
      end
      want = key_results.pop_front();
      checked++;
      if (got.hash_value !== want.hash_value) begin
        $error("hash_value: expected %h, got %h", want.hash_value, got.hash_value);
        errors++;
      end
      if (got.bucket_index !== want.bucket_index) begin
        $error("bucket_index: expected %0d, got %0d", want.bucket_index, got.bucket_index);
        errors++;
      end
      if (got.bad_count !== want.bad_count) begin
        $error("bad_count: expected %0b, got %0b", want.bad_count, got.bad_count);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [COUNT_BITS-1:0] cfg_data;

  key_hash_scoreboard board = new();

  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned key_items;
  int unsigned filler_items;
  int unsigned count_writes;
  int unsigned quiet_cycles;

  fnv1a64_bucket_index u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Check every accepted result beat
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check_result(out_data);
    end
  end

  // Abort when no beat moves on any channel for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no beat moved for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, board.pending());
      $display("FAIL fnv1a64_bucket_index");
      $finish;
    end
  end

  // Hold one beat until accepted, with random idle cycles ahead of it
  task automatic send_item(in_item_t item);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    board.note_item(item);
    if (item.has_byte || item.last) key_items++;
    else filler_items++;
    @(negedge clk);
  endtask

  function automatic in_item_t rand_tail(logic last);
    in_item_t item;
    item.data_byte = 8'($urandom_range(255));
    item.has_byte  = 1'b0;
    item.last      = last;
    return item;
  endfunction

  // Send one key with random bytes, stray fillers and an optional empty end
  task automatic send_random_key();
    in_item_t    item;
    int unsigned roll;
    int unsigned nbytes;
    bit          empty_end;
    roll      = $urandom_range(99);
    nbytes    = (roll < 5) ? 0 : (roll < 15) ? $urandom_range(48, 9) : $urandom_range(8, 1);
    empty_end = ($urandom_range(99) < 20);
    for (int unsigned i = 0; i < nbytes; i++) begin
      if ($urandom_range(99) < FILLER_PCT) send_item(rand_tail(1'b0));
      item.data_byte = 8'($urandom_range(255));
      item.has_byte  = 1'b1;
      item.last      = !empty_end && (i == nbytes - 1);
      send_item(item);
    end
    if (empty_end || nbytes == 0) send_item(rand_tail(1'b1));
  endtask

  // Drop valid, wait for every owed result, then let the remainder unit settle
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Write the bucket count; called at a falling edge
  task automatic write_count(logic [COUNT_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    board.set_count(value);
    count_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [COUNT_BITS-1:0] phase_counts [9];
    int unsigned           start_items;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    out_stall    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    idle_pct     = 0;
    stall_pct    = 0;
    key_items    = 0;
    filler_items = 0;
    count_writes = 0;
    quiet_cycles = 0;

    phase_counts = '{17'd0, 17'd1, 17'd65536, 17'd131071, 17'd65535, 17'd2, 17'd65537,
                     17'($urandom_range(65534, 3)), RESET_COUNT};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Scripted keys at the reset bucket count, back to back
    foreach (KEY_SCRIPT[i]) send_item(KEY_SCRIPT[i]);
    drain();

    // Random keys under each bucket count, cycling through the idle and stall patterns
    foreach (phase_counts[p]) begin
      write_count(phase_counts[p]);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 59; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 59; end
        default: begin idle_pct = 35; stall_pct = 35; end
      endcase
      start_items = key_items;
      while (key_items - start_items < PHASE_ITEMS) send_random_key();
      drain();
    end

    $display("sent %0d key beats and %0d fillers; %0d hash results checked",
             key_items, filler_items, board.checked);
    $display("bucket count written %0d times, from zero and one up to the 17-bit maximum",
             count_writes);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("PASS fnv1a64_bucket_index");
    end else begin
      $display("FAIL fnv1a64_bucket_index");
    end
    $finish;
  end

endmodule
